>>> hw/rtl/rotated_mono_framebuffer_plotter_unit_defines.svh
// Assertion macros for the plotter RTL.
`ifndef ROTATED_MONO_FRAMEBUFFER_PLOTTER_UNIT_DEFINES_SVH
`define ROTATED_MONO_FRAMEBUFFER_PLOTTER_UNIT_DEFINES_SVH

`ifndef NO_ASSERTIONS
// cond must hold at every clock edge outside reset
`define RMFP_ASSERT_HOLDS(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
// ante at an edge implies cons at the same edge
`define RMFP_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`else
`define RMFP_ASSERT_HOLDS(lbl, cond, msg)
`define RMFP_ASSERT_IMPL(lbl, ante, cons, msg)
`endif

`endif

>>> hw/rtl/rmfp_pkg.sv
// Shared types and constants of the rotated mono framebuffer plotter.
package rmfp_pkg;

    localparam int MAX_WIDTH   = 256;
    localparam int MAX_HEIGHT  = 256;
    localparam int FRAME_DEPTH = 8192;
    localparam int ADDR_W      = $clog2(FRAME_DEPTH);
    localparam int MAX_DIM     = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
    localparam int COORD_W     = $clog2(MAX_DIM);
    localparam int DIM_W       = 9;
    localparam int STRIDE_W    = $clog2(MAX_WIDTH / 8) + 1;
    localparam int STEP_W      = $clog2(STRIDE_W + 1);
    localparam int PROD_W      = COORD_W + STRIDE_W;
    localparam int SUM_W       = PROD_W + 1;
    localparam int BYTE_COL_W  = COORD_W - 3;
    localparam int SPAN_MAX    = 8;
    localparam int LEN_W       = 4;
    localparam logic [7:0] MSB_MASK = 8'h80;

    // input beat layout in s_tdata
    localparam int POS_X_LSB   = 0;
    localparam int POS_Y_LSB   = 16;
    localparam int PAT_LSB     = 32;
    localparam int LEN_LSB     = 40;
    localparam int FG_BIT      = 44;
    localparam int BG_BIT      = 45;
    localparam int OPQ_BIT     = 46;
    localparam int RADDR_LSB   = 47;
    localparam int IN_DATA_W   = 64;

    // register map
    localparam int PADDR_W     = 4;
    localparam int REG_IDX_W   = 2;
    localparam logic [REG_IDX_W-1:0] REG_PANEL_WIDTH  = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_PANEL_HEIGHT = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_ROTATION     = 2'd2;
    localparam logic [DIM_W-1:0] WIDTH_RESET  = 9'd128;
    localparam logic [DIM_W-1:0] HEIGHT_RESET = 9'd64;

    typedef enum logic [1:0] {
        ROT_0   = 2'd0,
        ROT_90  = 2'd1,
        ROT_180 = 2'd2,
        ROT_270 = 2'd3
    } rot_t;

    typedef enum logic {
        ACT_DRAW = 1'b0,
        ACT_READ = 1'b1
    } action_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_RD_ISSUE,
        S_RD_DATA,
        S_PIX,
        S_MUL,
        S_ADDR,
        S_RMW
    } state_t;

    typedef struct packed {
        logic              rd_en;
        logic              wr_en;
        logic [ADDR_W-1:0] addr;
        logic [7:0]        wdata;
    } store_req_t;

    typedef struct packed {
        logic                start;
        logic [COORD_W-1:0]  row;
        logic [STRIDE_W-1:0] stride;
    } mul_req_t;

endpackage

>>> hw/rtl/rmfp_mul.sv
// Bit-serial row offset multiplier: row times stride, one stride bit per cycle.
module rmfp_mul
    import rmfp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  mul_req_t          req,
    output logic              done,
    output logic [PROD_W-1:0] product
);

    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [STEP_W-1:0]   step_reg, step_next;
    logic [PROD_W-1:0]   acc_reg, acc_next;
    logic [PROD_W-1:0]   mcand_reg, mcand_next;
    logic [STRIDE_W-1:0] mplier_reg, mplier_next;

    always_comb
    begin
        busy_next   = busy_reg;
        done_next   = 1'b0;
        step_next   = step_reg;
        acc_next    = acc_reg;
        mcand_next  = mcand_reg;
        mplier_next = mplier_reg;
        if (req.start)
        begin
            busy_next   = 1'b1;
            step_next   = '0;
            acc_next    = '0;
            mcand_next  = PROD_W'(req.row);
            mplier_next = req.stride;
        end
        else if (busy_reg)
        begin
            if (mplier_reg[0])
                acc_next = acc_reg + mcand_reg;
            mcand_next  = mcand_reg << 1;
            mplier_next = mplier_reg >> 1;
            step_next   = step_reg + 1'b1;
            if (step_reg == STEP_W'(STRIDE_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg    <= acc_next;
        mcand_reg  <= mcand_next;
        mplier_reg <= mplier_next;
    end

    assign done    = done_reg;
    assign product = acc_reg;

endmodule

>>> hw/rtl/rmfp_store.sv
// Framebuffer byte store with a zeroing sweep after reset.
module rmfp_store
    import rmfp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  store_req_t req,
    output logic       ready,
    output logic [7:0] rdata
);

    logic [7:0]        mem [FRAME_DEPTH];
    logic              clearing_reg, clearing_next;
    logic [ADDR_W-1:0] clr_addr_reg, clr_addr_next;
    logic [7:0]        rdata_reg;

    always_comb
    begin
        clearing_next = clearing_reg;
        clr_addr_next = clr_addr_reg;
        if (clearing_reg)
        begin
            clr_addr_next = clr_addr_reg + 1'b1;
            if (clr_addr_reg == ADDR_W'(FRAME_DEPTH - 1))
                clearing_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg <= 1'b1;
            clr_addr_reg <= '0;
        end
        else
        begin
            clearing_reg <= clearing_next;
            clr_addr_reg <= clr_addr_next;
        end
    end

    // single write port, shared between the sweep and pixel updates
    always_ff @(posedge clk)
    begin
        if (clearing_reg)
            mem[clr_addr_reg] <= 8'h00;
        else if (req.wr_en)
            mem[req.addr] <= req.wdata;
    end

    always_ff @(posedge clk)
    begin
        if (req.rd_en)
            rdata_reg <= mem[req.addr];
    end

    assign ready = !clearing_reg;
    assign rdata = rdata_reg;

endmodule

>>> hw/rtl/rotated_mono_framebuffer_plotter_unit.sv
// Read beat: it passes S_RD_ISSUE, which waits while the last byte is still held, then S_RD_DATA,
// which raises m_tvalid. Only one beat is in flight: the input stays closed until the read or draw is done.
// Draw beat: a pixel step for each clipped or skipped pixel; a drawn pixel adds a wait on the
// 6-step bit-serial row multiply, a store read and a store write; a last step finishes the beat.
// Reset (rst_n, async, low): registers to 128 x 64, no rotation; the store is then swept to zero,
// all 8192 bytes, and the input opens in the cycle after it ends (APB writes still taken).
module rotated_mono_framebuffer_plotter_unit
    import rmfp_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    // stream in
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // [15:0] pos_x, [31:16] pos_y, [39:32] pattern_bits, [43:40] span_length,
    // [44] fg_color, [45] bg_color, [46] opaque, [59:47] read_address, [63:60] zero
    input  logic [IN_DATA_W-1:0] s_tdata,
    input  logic                 s_tuser,   // [0] action
    // stream out
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [7:0]           m_tdata,   // [7:0] read_data
    // APB config port
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [PADDR_W-1:0]   paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);

`include "rotated_mono_framebuffer_plotter_unit_defines.svh"

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [DIM_W-1:0] panel_width_reg;
    logic [DIM_W-1:0] panel_height_reg;
    rot_t             rotation_reg;
    logic             cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            panel_width_reg  <= WIDTH_RESET;
            panel_height_reg <= HEIGHT_RESET;
            rotation_reg     <= ROT_0;
        end
        else if (cfg_wr)
        begin
            case (paddr[3:2])
                REG_PANEL_WIDTH:  panel_width_reg  <= pwdata[DIM_W-1:0];
                REG_PANEL_HEIGHT: panel_height_reg <= pwdata[DIM_W-1:0];
                REG_ROTATION:     rotation_reg     <= rot_t'(pwdata[1:0]);
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            REG_PANEL_WIDTH:  prdata = 32'(panel_width_reg);
            REG_PANEL_HEIGHT: prdata = 32'(panel_height_reg);
            REG_ROTATION:     prdata = 32'(rotation_reg);
            default:          prdata = '0;
        endcase
    end

    // Effective panel size: clamped to the framebuffer limits
    logic [DIM_W-1:0]    w_eff, h_eff, vw, vh, w_m1, h_m1;
    logic [DIM_W:0]      w_round;
    logic [STRIDE_W-1:0] stride;

    assign w_eff   = (panel_width_reg > DIM_W'(MAX_WIDTH)) ? DIM_W'(MAX_WIDTH)
                                                           : panel_width_reg;
    assign h_eff   = (panel_height_reg > DIM_W'(MAX_HEIGHT)) ? DIM_W'(MAX_HEIGHT)
                                                             : panel_height_reg;
    assign vw      = rotation_reg[0] ? h_eff : w_eff;
    assign vh      = rotation_reg[0] ? w_eff : h_eff;
    assign w_m1    = w_eff - 1'b1;
    assign h_m1    = h_eff - 1'b1;
    assign w_round = {1'b0, w_eff} + (DIM_W+1)'(7);
    assign stride  = w_round[STRIDE_W+2:3];   // bytes per row

    // ------------------------------------------------------------------
    // Sub-units
    // ------------------------------------------------------------------
    store_req_t        store_req;
    logic              store_ready;
    logic [7:0]        store_rdata;
    mul_req_t          mul_req;
    logic              mul_done;
    logic [PROD_W-1:0] mul_product;

    rmfp_store u_store (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (store_req),
        .ready (store_ready),
        .rdata (store_rdata)
    );

    rmfp_mul u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (mul_req),
        .done    (mul_done),
        .product (mul_product)
    );

    // ------------------------------------------------------------------
    // Beat context and per-pixel state
    // ------------------------------------------------------------------
    state_t             state_reg, state_next;
    logic [LEN_W-1:0]   pix_reg, pix_next;
    logic               out_valid_reg, out_valid_next;

    logic signed [16:0] x_cur_reg, x_cur_next;     // grows past 32767 on the last pixels
    logic [15:0]        y_reg, y_next;
    logic [7:0]         pat_reg, pat_next;         // shifts left, bit 7 is current pixel
    logic [LEN_W-1:0]   len_reg, len_next;
    logic               fg_reg, fg_next;
    logic               bg_reg, bg_next;
    logic               opq_reg, opq_next;
    logic [ADDR_W-1:0]  raddr_reg, raddr_next;
    logic [COORD_W-1:0] px_reg, px_next;
    logic               color_reg, color_next;
    logic [7:0]         out_data_reg, out_data_next;

    // current pixel: clip in virtual space, then rotate
    logic               in_clip;
    logic [COORD_W-1:0] xv, yv, px_c, py_c;
    logic [LEN_W-1:0]   len_in;
    logic [SUM_W-1:0]   byte_index;
    logic [7:0]         pix_mask;

    assign in_clip = !x_cur_reg[16] && (x_cur_reg[15:0] < 16'(vw))
                  && !y_reg[15] && (y_reg < 16'(vh));
    assign xv = x_cur_reg[COORD_W-1:0];
    assign yv = y_reg[COORD_W-1:0];

    always_comb
    begin
        case (rotation_reg)
            ROT_90:
            begin
                px_c = w_m1[COORD_W-1:0] - yv;
                py_c = xv;
            end
            ROT_180:
            begin
                px_c = w_m1[COORD_W-1:0] - xv;
                py_c = h_m1[COORD_W-1:0] - yv;
            end
            ROT_270:
            begin
                px_c = yv;
                py_c = h_m1[COORD_W-1:0] - xv;
            end
            default:
            begin
                px_c = xv;
                py_c = yv;
            end
        endcase
    end

    assign len_in     = s_tdata[LEN_LSB +: LEN_W];
    assign byte_index = SUM_W'(mul_product) + SUM_W'(px_reg[COORD_W-1:3]);
    assign pix_mask   = MSB_MASK >> px_reg[2:0];

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    always_comb
    begin
        state_next     = state_reg;
        pix_next       = pix_reg;
        out_valid_next = out_valid_reg && !m_tready;
        x_cur_next     = x_cur_reg;
        y_next         = y_reg;
        pat_next       = pat_reg;
        len_next       = len_reg;
        fg_next        = fg_reg;
        bg_next        = bg_reg;
        opq_next       = opq_reg;
        raddr_next     = raddr_reg;
        px_next        = px_reg;
        color_next     = color_reg;
        out_data_next  = out_data_reg;
        store_req      = '0;
        mul_req        = '0;
        mul_req.row    = py_c;
        mul_req.stride = stride;

        case (state_reg)
            S_CLEAR:
            begin
                if (store_ready)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    x_cur_next = 17'(signed'(s_tdata[POS_X_LSB +: 16]));
                    y_next     = s_tdata[POS_Y_LSB +: 16];
                    pat_next   = s_tdata[PAT_LSB +: 8];
                    len_next   = (len_in > LEN_W'(SPAN_MAX)) ? LEN_W'(SPAN_MAX) : len_in;
                    fg_next    = s_tdata[FG_BIT];
                    bg_next    = s_tdata[BG_BIT];
                    opq_next   = s_tdata[OPQ_BIT];
                    raddr_next = s_tdata[RADDR_LSB +: ADDR_W];
                    pix_next   = '0;
                    state_next = (action_t'(s_tuser) == ACT_READ) ? S_RD_ISSUE : S_PIX;
                end
            end
            S_RD_ISSUE:
            begin
                // wait until the output register is free by the next edge
                if (!out_valid_reg || m_tready)
                begin
                    store_req.rd_en = 1'b1;
                    store_req.addr  = raddr_reg;
                    state_next      = S_RD_DATA;
                end
            end
            S_RD_DATA:
            begin
                out_data_next  = store_rdata;
                out_valid_next = 1'b1;
                state_next     = S_IDLE;
            end
            S_PIX:
            begin
                if (pix_reg == len_reg)
                    state_next = S_IDLE;
                else
                begin
                    pix_next   = pix_reg + 1'b1;
                    x_cur_next = x_cur_reg + 17'sd1;
                    pat_next   = pat_reg << 1;
                    // clear bits are only drawn in opaque mode
                    if (in_clip && (pat_reg[7] || opq_reg))
                    begin
                        px_next       = px_c;
                        color_next    = pat_reg[7] ? fg_reg : bg_reg;
                        mul_req.start = 1'b1;
                        state_next    = S_MUL;
                    end
                end
            end
            S_MUL:
            begin
                if (mul_done)
                    state_next = S_ADDR;
            end
            S_ADDR:
            begin
                if (byte_index < SUM_W'(FRAME_DEPTH))
                begin
                    store_req.rd_en = 1'b1;
                    store_req.addr  = byte_index[ADDR_W-1:0];
                    state_next      = S_RMW;
                end
                else
                    state_next = S_PIX;
            end
            S_RMW:
            begin
                store_req.wr_en = 1'b1;
                store_req.addr  = byte_index[ADDR_W-1:0];
                store_req.wdata = color_reg ? (store_rdata | pix_mask)
                                            : (store_rdata & ~pix_mask);
                state_next      = S_PIX;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            pix_reg       <= '0;
            len_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pix_reg       <= pix_next;
            len_reg       <= len_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_cur_reg    <= x_cur_next;
        y_reg        <= y_next;
        pat_reg      <= pat_next;
        fg_reg       <= fg_next;
        bg_reg       <= bg_next;
        opq_reg      <= opq_next;
        raddr_reg    <= raddr_next;
        px_reg       <= px_next;
        color_reg    <= color_next;
        out_data_reg <= out_data_next;
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `RMFP_ASSERT_IMPL(a_ready_after_sweep, s_tready, store_ready,
        "input taken while store sweep still running")
    `RMFP_ASSERT_IMPL(a_mul_done_in_wait, mul_done, state_reg == S_MUL,
        "multiplier finished outside the multiply wait")
    `RMFP_ASSERT_IMPL(a_out_from_read, $rose(m_tvalid), $past(state_reg == S_RD_DATA),
        "output beat raised without a store read")
    `RMFP_ASSERT_IMPL(a_write_in_rmw, store_req.wr_en, state_reg == S_RMW && store_ready,
        "store write outside a pixel update")

endmodule
